@@ rtl/mcop_pkg.sv @@
// ----------------------------------------------------------------------------
// mcop_pkg
// Shared types and constants for the Monte Carlo European option pricer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcop_pkg;

   // Accumulator and path counter widths.
   localparam int SUM_WIDTH     = 64;
   localparam int COUNT_WIDTH   = 32;
   localparam int DIV_CNT_WIDTH = $clog2(SUM_WIDTH) + 1;

   // Fixed-point constants.
   localparam logic [33:0] LOG2E_Q30 = 34'd1549082005;
   localparam logic [33:0] LN2_Q30   = 34'd744261118;
   localparam logic [31:0] Q30_ONE   = 32'd1073741824;
   localparam logic [31:0] MAX32     = 32'hFFFF_FFFF;

   // Configuration register indexes.
   localparam logic [2:0] CSR_FORWARD_SPOT    = 3'd0;
   localparam logic [2:0] CSR_ROOT_VARIANCE   = 3'd1;
   localparam logic [2:0] CSR_STRIKE_PRICE    = 3'd2;
   localparam logic [2:0] CSR_DISCOUNT_FACTOR = 3'd3;
   localparam logic [2:0] CSR_PUT_MODE        = 3'd4;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_Y,
      ST_MUL_U,
      ST_LOAD_U,
      ST_HORNER_MUL,
      ST_HORNER_RECIP,
      ST_HORNER_FIX,
      ST_MUL_SPOT,
      ST_ACCUM,
      ST_DIVIDE,
      ST_MUL_HI,
      ST_MUL_LO,
      ST_OUTPUT
   } state_type;

   // Reciprocal of the Horner divisor: floor((2^33 - 1) / k), k from 1 to 9.
   function automatic logic [33:0] horner_recip(input logic [3:0] k);
      logic [33:0] r;
      case (k)
         4'd1:    r = 34'd8589934591;
         4'd2:    r = 34'd4294967295;
         4'd3:    r = 34'd2863311530;
         4'd4:    r = 34'd2147483647;
         4'd5:    r = 34'd1717986918;
         4'd6:    r = 34'd1431655765;
         4'd7:    r = 34'd1227133513;
         4'd8:    r = 34'd1073741823;
         4'd9:    r = 34'd954437176;
         default: r = 34'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/mc_european_option_pricer.sv @@
// ----------------------------------------------------------------------------
// mc_european_option_pricer
// Monte Carlo European call/put pricer around one shared multiplier.
// ----------------------------------------------------------------------------
// Path beat: a beat runs from start until busy goes low (exp series of
// nine Horner terms, three states each, two of them on the shared multiplier).
// A last-path beat adds the divider and the discount steps (MUL_HI, MUL_LO,
// OUTPUT), then rsp_strobe pulses for one cycle; the receiver cannot stall.
// A new beat is taken only in idle, once busy has gone low.
// Reset clears the sum, count, strobe and sequencer, and the configuration registers take their reset values.
`default_nettype none

module mc_european_option_pricer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic signed [15:0]  req_normal_sample,
   input  wire logic                req_last_path,
   output logic                     rsp_strobe,
   output logic [31:0]              rsp_option_price,
   output logic [31:0]              rsp_paths_used,
   input  wire logic                csr_write_enable,
   input  wire logic [2:0]          csr_index,
   input  wire logic [31:0]         csr_write_data
);
   import mcop_pkg::*;

   // Configuration registers.
   logic [31:0] fwd_spot_ff, strike_ff;
   logic [15:0] root_var_ff, discount_ff;
   logic        put_mode_ff;

   // Sequencer and datapath registers.
   state_type               state_ff, state_in;
   logic signed [15:0]      sample_ff, sample_in;
   logic                    last_ff, last_in;
   logic signed [33:0]      mul_a, mul_b;
   logic signed [67:0]      mul_p_ff;
   logic signed [6:0]       n_ff, n_in;
   logic [29:0]             u_ff, u_in;
   logic [31:0]             a_ff, a_in;
   logic [31:0]             t_ff, t_in;
   logic [3:0]              k_ff, k_in;
   logic [47:0]             hp_ff, hp_in;
   logic [SUM_WIDTH-1:0]    sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                    strobe_ff, strobe_in;
   logic [31:0]             price_ff, price_in;
   logic [31:0]             paths_ff, paths_in;
   logic                    div_start, div_done;
   logic [SUM_WIDTH-1:0]    mean;

   // Helper values.
   logic signed [67:0]      y_full;
   logic [31:0]             q_est;
   logic [35:0]             qk, rem;
   logic signed [7:0]       sh;
   logic [4:0]              lsh;
   logic [63:0]             prod, prod_rsh;
   logic [31:0]             spot, pay;
   logic [SUM_WIDTH:0]      sum_ext;
   logic [48:0]             price_full;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_spot_ff <= '0;
         root_var_ff <= '0;
         strike_ff   <= '0;
         discount_ff <= 16'd32768;
         put_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FORWARD_SPOT:    fwd_spot_ff <= csr_write_data;
            CSR_ROOT_VARIANCE:   root_var_ff <= csr_write_data[15:0];
            CSR_STRIKE_PRICE:    strike_ff   <= csr_write_data;
            CSR_DISCOUNT_FACTOR: discount_ff <= csr_write_data[15:0];
            CSR_PUT_MODE:        put_mode_ff <= csr_write_data[0];
            default:             ;
         endcase
      end
   end

   // Divider for the mean payoff. It loads the sum that includes the last path.
   mcop_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (mean)
   );

   // Horner quotient check, terminal spot scaling, payoff, sum and discounted price, from the registered product.
   always_comb begin
      y_full   = mul_p_ff >>> 30;
      q_est    = mul_p_ff[64:33];
      qk       = {4'd0, q_est} * {32'd0, k_ff};
      rem      = {4'd0, t_ff} - qk;
      prod     = mul_p_ff[63:0];
      sh       = 8'sd30 - 8'(n_ff);
      lsh      = 5'(-sh);
      prod_rsh = prod >> sh[5:0];
      if (sh >= 8'sd64) begin
         spot = '0;
      end else if (sh >= 8'sd0) begin
         spot = (prod_rsh > {32'd0, MAX32}) ? MAX32 : prod_rsh[31:0];
      end else if (prod == 64'd0) begin
         spot = '0;
      end else if (prod > {32'd0, MAX32 >> lsh}) begin
         spot = MAX32;
      end else begin
         spot = prod[31:0] << lsh;
      end
      if (put_mode_ff) begin
         pay = (strike_ff > spot) ? strike_ff - spot : '0;
      end else begin
         pay = (spot > strike_ff) ? spot - strike_ff : '0;
      end
      sum_ext    = {1'b0, sum_ff} + (SUM_WIDTH + 1)'(pay);
      price_full = {1'b0, hp_ff} + 49'(mul_p_ff[30:15]);
   end

   // Sequencer: next state, multiplier operands and datapath updates.
   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      last_in   = last_ff;
      n_in      = n_ff;
      u_in      = u_ff;
      a_in      = a_ff;
      t_in      = t_ff;
      k_in      = k_ff;
      hp_in     = hp_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      strobe_in = 1'b0;
      price_in  = price_ff;
      paths_in  = paths_ff;
      div_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               sample_in = req_normal_sample;
               last_in   = req_last_path;
               state_in  = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            mul_a    = {18'd0, root_var_ff};
            mul_b    = 34'(sample_ff);
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            mul_a    = mul_p_ff[33:0];
            mul_b    = LOG2E_Q30;
            state_in = ST_MUL_U;
         end
         ST_MUL_U: begin
            // Split log2 of the growth into integer and fraction.
            n_in     = y_full[32:26];
            mul_a    = {8'd0, y_full[25:0]};
            mul_b    = LN2_Q30;
            state_in = ST_LOAD_U;
         end
         ST_LOAD_U: begin
            u_in     = mul_p_ff[55:26];
            a_in     = Q30_ONE;
            k_in     = 4'd9;
            state_in = ST_HORNER_MUL;
         end
         ST_HORNER_MUL: begin
            mul_a    = {2'd0, a_ff};
            mul_b    = {4'd0, u_ff};
            state_in = ST_HORNER_RECIP;
         end
         ST_HORNER_RECIP: begin
            t_in     = mul_p_ff[61:30];
            mul_a    = {2'd0, mul_p_ff[61:30]};
            mul_b    = horner_recip(k_ff);
            state_in = ST_HORNER_FIX;
         end
         ST_HORNER_FIX: begin
            // The reciprocal estimate is at most one short of the quotient.
            a_in = Q30_ONE + ((rem >= {32'd0, k_ff}) ? q_est + 32'd1 : q_est);
            if (k_ff == 4'd1) begin
               state_in = ST_MUL_SPOT;
            end else begin
               k_in     = k_ff - 4'd1;
               state_in = ST_HORNER_MUL;
            end
         end
         ST_MUL_SPOT: begin
            mul_a    = {2'd0, fwd_spot_ff};
            mul_b    = {2'd0, a_ff};
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            // Saturating accumulation of the payoff and the path count.
            sum_in   = sum_ext[SUM_WIDTH] ? '1 : sum_ext[SUM_WIDTH-1:0];
            count_in = (&count_ff) ? count_ff : count_ff + 1'b1;
            if (last_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_MUL_HI;
            end
         end
         ST_MUL_HI: begin
            mul_a    = {2'd0, mean[46:15]};
            mul_b    = {18'd0, discount_ff};
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            hp_in    = mul_p_ff[47:0];
            mul_a    = {19'd0, mean[14:0]};
            mul_b    = {18'd0, discount_ff};
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (discount_ff == 16'd0) begin
               price_in = '0;
            end else if (|mean[SUM_WIDTH-1:47]) begin
               price_in = MAX32;
            end else if (|price_full[48:32]) begin
               price_in = MAX32;
            end else begin
               price_in = price_full[31:0];
            end
            paths_in  = 32'(count_ff);
            strobe_in = 1'b1;
            sum_in    = '0;
            count_in  = '0;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sum_ff    <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      sample_ff <= sample_in;
      last_ff   <= last_in;
      mul_p_ff  <= mul_a * mul_b;
      n_ff      <= n_in;
      u_ff      <= u_in;
      a_ff      <= a_in;
      t_ff      <= t_in;
      k_ff      <= k_in;
      hp_ff     <= hp_in;
      price_ff  <= price_in;
      paths_ff  <= paths_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_option_price = price_ff;
   assign rsp_paths_used   = paths_ff;

endmodule

`default_nettype wire

@@ rtl/mcop_div.sv @@
// ----------------------------------------------------------------------------
// mcop_div
// Restoring divider, one quotient bit per cycle, for the mean payoff.
// ----------------------------------------------------------------------------
`default_nettype none

module mcop_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [mcop_pkg::SUM_WIDTH-1:0]      dividend,
   input  wire logic [mcop_pkg::COUNT_WIDTH-1:0]    divisor,
   output logic                                     done,
   output logic [mcop_pkg::SUM_WIDTH-1:0]           quotient
);
   import mcop_pkg::*;

   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [DIV_CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [COUNT_WIDTH-1:0]     rem_ff, rem_in;
   logic [SUM_WIDTH-1:0]       quo_ff, quo_in;
   logic [COUNT_WIDTH:0]       trial;
   logic                       fits;

   // One restoring step: bring down the next dividend bit and try to subtract.
   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_WIDTH-1]};
      fits    = trial >= {1'b0, divisor};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = DIV_CNT_WIDTH'(SUM_WIDTH);
         rem_in = '0;
         quo_in = dividend;
      end else if (run_ff) begin
         rem_in = fits ? COUNT_WIDTH'(trial - {1'b0, divisor}) : trial[COUNT_WIDTH-1:0];
         quo_in = {quo_ff[SUM_WIDTH-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_WIDTH'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire
